/* hw/rtl/gbfp_pkg.sv */
// Shared types and constants of the binary GNSS frame parser.
package gbfp_pkg;

    localparam logic [7:0] SYNC_FIRST  = 8'hB5;
    localparam logic [7:0] SYNC_SECOND = 8'h62;

    localparam int unsigned MAX_BYTES_W = 17;
    localparam logic [MAX_BYTES_W-1:0] MAX_BYTES_RESET = 17'd1024;

    // Status codes reported with every byte
    localparam logic [3:0] ST_SYNC_PARTIAL  = 4'd0;
    localparam logic [3:0] ST_SYNC_OK       = 4'd1;
    localparam logic [3:0] ST_ID_PARTIAL    = 4'd2;
    localparam logic [3:0] ST_ID_DONE       = 4'd3;
    localparam logic [3:0] ST_LEN_PARTIAL   = 4'd4;
    localparam logic [3:0] ST_LEN_DONE      = 4'd5;
    localparam logic [3:0] ST_PAYLOAD       = 4'd6;
    localparam logic [3:0] ST_PAYLOAD_DONE  = 4'd7;
    localparam logic [3:0] ST_CK_PARTIAL    = 4'd8;
    localparam logic [3:0] ST_CK_OK         = 4'd9;
    localparam logic [3:0] ST_CK_ERROR      = 4'd10;
    localparam logic [3:0] ST_OUT_OF_SYNC   = 4'd11;
    localparam logic [3:0] ST_OVERFLOW      = 4'd12;

    // Register index on the configuration port
    localparam logic REG_MAX_FRAME_BYTES = 1'b0;

    typedef enum logic [4:0] {
        PH_HUNT    = 5'b00001,
        PH_CLASSID = 5'b00010,
        PH_LENGTH  = 5'b00100,
        PH_PAYLOAD = 5'b01000,
        PH_CK      = 5'b10000
    } phase_t;

    typedef struct packed {
        phase_t                 phase;
        logic [MAX_BYTES_W-1:0] frame_pos;
        logic [15:0]            remaining;
        logic [7:0]             held_byte;
        logic [7:0]             sum_a;
        logic [7:0]             sum_b;
        logic [7:0]             msg_class;
        logic [7:0]             msg_id;
        logic [15:0]            length;
    } parse_state_t;

    typedef struct packed {
        logic [3:0]  status;
        logic [7:0]  data_byte;
        logic [7:0]  msg_class;
        logic [7:0]  msg_id;
        logic [15:0] payload_length;
        logic        frame_end;
    } parse_result_t;

    localparam parse_state_t STATE_RESET = '{
        phase:     PH_HUNT,
        frame_pos: '0,
        remaining: 16'd2,
        held_byte: 8'd0,
        sum_a:     8'd0,
        sum_b:     8'd0,
        msg_class: 8'd0,
        msg_id:    8'd0,
        length:    16'd0
    };

endpackage

/* hw/rtl/gbfp_parse_step.sv */
// Per-byte next-state and status logic of the frame parser.
module gbfp_parse_step (
    input  gbfp_pkg::parse_state_t          cur_state,
    input  logic [7:0]                      rx_byte,
    input  logic [gbfp_pkg::MAX_BYTES_W-1:0] max_frame_bytes,
    output gbfp_pkg::parse_state_t          nxt_state,
    output gbfp_pkg::parse_result_t         result
);
    import gbfp_pkg::*;

    logic [MAX_BYTES_W:0] pos_inc;
    logic [7:0]           fl_a;
    logic [7:0]           fl_b;
    logic [15:0]          len_full;
    parse_state_t         upd;
    logic [3:0]           status;
    logic                 frame_end;

    assign pos_inc  = {1'b0, cur_state.frame_pos} + {{MAX_BYTES_W{1'b0}}, 1'b1};
    assign fl_a     = cur_state.sum_a + rx_byte;
    assign fl_b     = cur_state.sum_b + fl_a;
    assign len_full = {rx_byte, cur_state.length[7:0]};

    always_comb begin
        upd       = cur_state;
        status    = ST_OVERFLOW;
        frame_end = 1'b0;
        if (pos_inc > {1'b0, max_frame_bytes}) begin
            // drop the byte; the result keeps the aborted frame's fields
            status    = ST_OVERFLOW;
            frame_end = 1'b1;
        end else begin
            upd.frame_pos = pos_inc[MAX_BYTES_W-1:0];
            case (cur_state.phase)
                PH_CLASSID: begin
                    upd.sum_a = fl_a;
                    upd.sum_b = fl_b;
                    if (cur_state.remaining >= 16'd2) begin
                        upd.msg_class = rx_byte;
                        upd.remaining = 16'd1;
                        status        = ST_ID_PARTIAL;
                    end else begin
                        upd.msg_id    = rx_byte;
                        upd.phase     = PH_LENGTH;
                        upd.remaining = 16'd2;
                        status        = ST_ID_DONE;
                    end
                end
                PH_LENGTH: begin
                    upd.sum_a = fl_a;
                    upd.sum_b = fl_b;
                    if (cur_state.remaining >= 16'd2) begin
                        upd.length    = {8'd0, rx_byte};
                        upd.remaining = 16'd1;
                        status        = ST_LEN_PARTIAL;
                    end else begin
                        upd.length = len_full;
                        if (len_full != 16'd0) begin
                            upd.phase     = PH_PAYLOAD;
                            upd.remaining = len_full;
                        end else begin
                            // empty payload: go straight to the checksum
                            upd.phase     = PH_CK;
                            upd.remaining = 16'd2;
                        end
                        status = ST_LEN_DONE;
                    end
                end
                PH_PAYLOAD: begin
                    upd.sum_a = fl_a;
                    upd.sum_b = fl_b;
                    if (cur_state.remaining <= 16'd1) begin
                        upd.phase     = PH_CK;
                        upd.remaining = 16'd2;
                        status        = ST_PAYLOAD_DONE;
                    end else begin
                        upd.remaining = cur_state.remaining - 16'd1;
                        status        = ST_PAYLOAD;
                    end
                end
                PH_CK: begin
                    if (cur_state.remaining >= 16'd2) begin
                        upd.held_byte = rx_byte;
                        upd.remaining = 16'd1;
                        status        = ST_CK_PARTIAL;
                    end else begin
                        status = (cur_state.held_byte == cur_state.sum_a &&
                                  rx_byte == cur_state.sum_b) ? ST_CK_OK : ST_CK_ERROR;
                        frame_end = 1'b1;
                    end
                end
                default: begin
                    // sync hunt, pairwise
                    if (cur_state.remaining >= 16'd2) begin
                        upd.held_byte = rx_byte;
                        upd.remaining = 16'd1;
                        status        = ST_SYNC_PARTIAL;
                    end else if (cur_state.held_byte == SYNC_FIRST &&
                                 rx_byte == SYNC_SECOND) begin
                        upd.phase     = PH_CLASSID;
                        upd.remaining = 16'd2;
                        upd.sum_a     = 8'd0;
                        upd.sum_b     = 8'd0;
                        status        = ST_SYNC_OK;
                    end else begin
                        status    = ST_OUT_OF_SYNC;
                        frame_end = 1'b1;
                    end
                end
            endcase
        end
    end

    always_comb begin
        result.status         = status;
        result.data_byte      = rx_byte;
        result.msg_class      = upd.msg_class;
        result.msg_id         = upd.msg_id;
        result.payload_length = upd.length;
        result.frame_end      = frame_end;
        nxt_state             = frame_end ? STATE_RESET : upd;
    end

endmodule

/* hw/rtl/gnss_binary_frame_parser_core.sv */
// Top level of the binary GNSS frame parser: stream ports, register port, state.
//
// Usage:
//   Feed received serial bytes one per transfer on the s_ channel (s_tdata).
//   Every accepted byte yields exactly one status transfer on the m_ channel:
//   status, the echoed byte, and the class, id and payload length of the
//   current frame. m_tlast is high on a frame-ending transfer (checksum ok,
//   checksum error, out of sync, overflow); the parser then hunts for the
//   next sync pair. Capture payload bytes from m_tdata while status shows
//   payload or payload done.
//   The status of an accepted byte is registered; it shows from the next cycle.
//   Throughput: one byte per cycle unless the output stalls; the parse state
//   is updated in the same cycle the byte is taken, so bytes may arrive back to back.
//   Stall: the single output register holds its transfer while m_tready is
//   low; s_tready is high whenever that register is empty or being drained.
//   Reset (aresetn low, synchronous): parser returns to the sync hunt,
//   max_frame_bytes returns to 1024, the output register empties.
//   Register 0 (byte address 0): max_frame_bytes, 17 bits. Write it only
//   while no byte is in flight.
module gnss_binary_frame_parser_core (
    input  logic        aclk,
    input  logic        aresetn,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] rx_byte
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // [3:0] status, [11:4] data_byte, [19:12] msg_class,
                                   // [27:20] msg_id, [43:28] payload_length, [47:44] zero
    output logic        m_tlast,   // frame_end
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import gbfp_pkg::*;

    parse_state_t           state_reg;
    parse_state_t           state_next;
    parse_result_t          res_reg;
    parse_result_t          res_next;
    logic                   m_tvalid_reg;
    logic [MAX_BYTES_W-1:0] max_bytes_reg;
    logic                   in_xfer;
    logic                   cfg_wr;

    assign pready   = 1'b1;
    assign cfg_wr   = psel && penable && pwrite && pready;
    assign s_tready = !m_tvalid_reg || m_tready;
    assign in_xfer  = s_tvalid && s_tready;

    // configuration register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_bytes_reg <= MAX_BYTES_RESET;
        end else if (cfg_wr && paddr[2] == REG_MAX_FRAME_BYTES) begin
            max_bytes_reg <= pwdata[MAX_BYTES_W-1:0];
        end
    end

    always_comb begin
        prdata = 32'd0;
        if (paddr[2] == REG_MAX_FRAME_BYTES) begin
            prdata = {{(32-MAX_BYTES_W){1'b0}}, max_bytes_reg};
        end
    end

    gbfp_parse_step u_step (
        .cur_state       (state_reg),
        .rx_byte         (s_tdata),
        .max_frame_bytes (max_bytes_reg),
        .nxt_state       (state_next),
        .result          (res_next)
    );

    // advance the parse state on every accepted byte
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= STATE_RESET;
        end else if (in_xfer) begin
            state_reg <= state_next;
        end
    end

    // output register: load on accept, drop once taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (in_xfer) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_xfer) begin
            res_reg <= res_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tlast  = res_reg.frame_end;
    assign m_tdata  = {4'd0, res_reg.payload_length, res_reg.msg_id, res_reg.msg_class,
                       res_reg.data_byte, res_reg.status};

    // a frame-ending result leaves the parser back in the hunt at position zero
    a_end_restarts: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_xfer && res_next.frame_end) |=>
            (state_reg.phase == PH_HUNT && state_reg.frame_pos == '0 &&
             state_reg.remaining == 16'd2))
        else $error("parser not restarted after frame end");

    // tlast marks exactly the terminal statuses
    a_last_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg |-> (m_tlast == (res_reg.status == ST_CK_OK ||
                                      res_reg.status == ST_CK_ERROR ||
                                      res_reg.status == ST_OUT_OF_SYNC ||
                                      res_reg.status == ST_OVERFLOW)))
        else $error("m_tlast disagrees with status");

    // input side stalls only behind a held result
    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (m_tvalid_reg && !m_tready))
        else $error("input stalled without a held result");

    // outside the payload the byte counter only counts pairs
    a_pair_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg.phase != PH_PAYLOAD) |->
            (state_reg.remaining == 16'd1 || state_reg.remaining == 16'd2))
        else $error("pair counter out of range");

    // an unstalled held result is replaced or retired in the next cycle
    a_drain: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid_reg && m_tready && !in_xfer) |=> !m_tvalid_reg)
        else $error("result not retired after transfer");

endmodule

/* verif/gbfp_status_checker.sv */
`timescale 1ns / 1ps
// Status checker: tracks frames from accepted bytes and compares every status transfer.
module gbfp_status_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [47:0] m_tdata,
    input  logic        m_tlast,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    output int          mismatch_count,
    output int          statuses_due
);
    import gbfp_pkg::*;

    logic [MAX_BYTES_W-1:0] frame_limit;
    parse_state_t           track;
    parse_result_t          status_due[$];

    initial begin
        mismatch_count = 0;
        statuses_due   = 0;
    end

    function automatic void restart_hunt();
        track.phase     = PH_HUNT;
        track.frame_pos = '0;
        track.remaining = 16'd2;
        track.held_byte = 8'd0;
        track.sum_a     = 8'd0;
        track.sum_b     = 8'd0;
        track.msg_class = 8'd0;
        track.msg_id    = 8'd0;
        track.length    = 16'd0;
    endfunction

    function automatic void fold_checksum(input logic [7:0] b);
        track.sum_a = track.sum_a + b;
        track.sum_b = track.sum_b + track.sum_a;
    endfunction

    // Advance the tracked frame by one byte and return the status it must produce.
    function automatic parse_result_t next_status(input logic [7:0] b);
        parse_result_t r;
        logic          ends;
        ends        = 1'b0;
        r.data_byte = b;
        if ({1'b0, track.frame_pos} + 18'd1 > {1'b0, frame_limit}) begin
            r.status = ST_OVERFLOW;
            ends     = 1'b1;
        end else begin
            track.frame_pos = track.frame_pos + 1'b1;
            case (track.phase)
                PH_CLASSID: begin
                    fold_checksum(b);
                    if (track.remaining >= 16'd2) begin
                        track.msg_class = b;
                        track.remaining = 16'd1;
                        r.status        = ST_ID_PARTIAL;
                    end else begin
                        track.msg_id    = b;
                        track.phase     = PH_LENGTH;
                        track.remaining = 16'd2;
                        r.status        = ST_ID_DONE;
                    end
                end
                PH_LENGTH: begin
                    fold_checksum(b);
                    if (track.remaining >= 16'd2) begin
                        track.length    = {8'h00, b};
                        track.remaining = 16'd1;
                        r.status        = ST_LEN_PARTIAL;
                    end else begin
                        track.length = {b, track.length[7:0]};
                        if (track.length != 16'd0) begin
                            track.phase     = PH_PAYLOAD;
                            track.remaining = track.length;
                        end else begin
                            track.phase     = PH_CK;
                            track.remaining = 16'd2;
                        end
                        r.status = ST_LEN_DONE;
                    end
                end
                PH_PAYLOAD: begin
                    fold_checksum(b);
                    if (track.remaining <= 16'd1) begin
                        track.phase     = PH_CK;
                        track.remaining = 16'd2;
                        r.status        = ST_PAYLOAD_DONE;
                    end else begin
                        track.remaining = track.remaining - 16'd1;
                        r.status        = ST_PAYLOAD;
                    end
                end
                PH_CK: begin
                    if (track.remaining >= 16'd2) begin
                        track.held_byte = b;
                        track.remaining = 16'd1;
                        r.status        = ST_CK_PARTIAL;
                    end else begin
                        r.status = (track.held_byte == track.sum_a && b == track.sum_b) ?
                                   ST_CK_OK : ST_CK_ERROR;
                        ends     = 1'b1;
                    end
                end
                default: begin
                    if (track.remaining >= 16'd2) begin
                        track.held_byte = b;
                        track.remaining = 16'd1;
                        r.status        = ST_SYNC_PARTIAL;
                    end else if (track.held_byte == SYNC_FIRST && b == SYNC_SECOND) begin
                        track.phase     = PH_CLASSID;
                        track.remaining = 16'd2;
                        track.sum_a     = 8'd0;
                        track.sum_b     = 8'd0;
                        r.status        = ST_SYNC_OK;
                    end else begin
                        r.status = ST_OUT_OF_SYNC;
                        ends     = 1'b1;
                    end
                end
            endcase
        end
        r.msg_class      = track.msg_class;
        r.msg_id         = track.msg_id;
        r.payload_length = track.length;
        r.frame_end      = ends;
        if (ends)
            restart_hunt();
        return r;
    endfunction

    task automatic check_field(input string name, input logic [15:0] want, input logic [15:0] got);
        if (want !== got) begin
            mismatch_count++;
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
        end
    endtask

    always @(posedge aclk) begin
        parse_result_t want;
        if (!aresetn) begin
            frame_limit = MAX_BYTES_RESET;
            restart_hunt();
            status_due.delete();
        end else begin
            if (psel && penable && pwrite && pready && paddr == 3'(4 * REG_MAX_FRAME_BYTES))
                frame_limit = pwdata[MAX_BYTES_W-1:0];
            if (m_tvalid && m_tready) begin
                if (status_due.size() == 0) begin
                    mismatch_count++;
                    $error("status transfer 0x%0h with no byte waiting for it", m_tdata);
                end else begin
                    want = status_due.pop_front();
                    check_field("status", 16'(want.status), 16'(m_tdata[3:0]));
                    check_field("data_byte", 16'(want.data_byte), 16'(m_tdata[11:4]));
                    check_field("msg_class", 16'(want.msg_class), 16'(m_tdata[19:12]));
                    check_field("msg_id", 16'(want.msg_id), 16'(m_tdata[27:20]));
                    check_field("payload_length", want.payload_length, m_tdata[43:28]);
                    check_field("frame_end", 16'(want.frame_end), 16'(m_tlast));
                end
            end
            if (s_tvalid && s_tready)
                status_due.push_back(next_status(s_tdata));
        end
        statuses_due = status_due.size();
    end

endmodule

/* verif/gnss_binary_frame_parser_core_test.sv */
`timescale 1ns / 1ps
// Regression top for the frame parser core: byte stimulus, register writes and the verdict.
module gnss_binary_frame_parser_core_test;
    import gbfp_pkg::*;

    localparam int HALF_PERIOD = 6;
    // Run limit in ns, far beyond the slowest legal run.
    localparam int RUN_LIMIT_NS = 2_000_000;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'd0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;
    logic        m_tlast;
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [2:0]  paddr    = 3'd0;
    logic [31:0] pwdata   = 32'd0;
    logic [31:0] prdata;
    logic        pready;

    int mismatch_count;
    int statuses_due;

    // Idle odds in percent for each side; the phases below change them.
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int bytes_sent    = 0;
    // Mirror of max_frame_bytes, used to keep runaway headers affordable.
    int frame_limit   = 1024;

    gnss_binary_frame_parser_core dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    gbfp_status_checker status_check (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tlast        (m_tlast),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .pready         (pready),
        .mismatch_count (mismatch_count),
        .statuses_due   (statuses_due)
    );

    always begin
        #HALF_PERIOD aclk = 1'b1;
        #HALF_PERIOD aclk = 1'b0;
    end

    // Receiver: drop m_tready at random with the current odds, fresh every cycle.
    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Offer one byte and hold it until the transfer happens. Idle cycles go in
    // front of the byte only, so s_tvalid never falls while a byte is offered.
    task automatic push_byte(input logic [7:0] b);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        do @(posedge aclk); while (!s_tready);
        bytes_sent++;
    endtask

    // Stop sending and hold off until every status has come back. Sample the
    // count at the falling edge, after the checker has settled for the cycle.
    task automatic drain_statuses();
        s_tvalid <= 1'b0;
        do @(negedge aclk); while (statuses_due != 0);
        // Let the registered output stage settle before anything else happens.
        repeat (2) @(posedge aclk);
    endtask

    // Setup cycle, then access cycle; the register takes the value at the
    // edge where pready is seen high with penable.
    task automatic write_frame_limit(input logic [MAX_BYTES_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= 3'(4 * REG_MAX_FRAME_BYTES);
        pwdata  <= 32'(value);
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        frame_limit = int'(value);
    endtask

    // Build a whole frame with a random payload, corrupt one checksum byte if
    // asked (1: CK_A, 2: CK_B) and send only the first max_bytes of it.
    task automatic send_frame(input logic [7:0] cls, input logic [7:0] id, input int len,
                              input int ck_fault, input int max_bytes);
        logic [7:0] frame_bytes[$];
        logic [7:0] ck_a;
        logic [7:0] ck_b;
        ck_a = 8'd0;
        ck_b = 8'd0;
        frame_bytes.push_back(SYNC_FIRST);
        frame_bytes.push_back(SYNC_SECOND);
        frame_bytes.push_back(cls);
        frame_bytes.push_back(id);
        frame_bytes.push_back(len[7:0]);
        frame_bytes.push_back(len[15:8]);
        for (int i = 0; i < len; i++)
            frame_bytes.push_back(8'($urandom));
        for (int i = 2; i < frame_bytes.size(); i++) begin
            ck_a = ck_a + frame_bytes[i];
            ck_b = ck_b + ck_a;
        end
        if (ck_fault == 1)
            ck_a = ck_a ^ (8'h01 << $urandom_range(7));
        if (ck_fault == 2)
            ck_b = ck_b ^ (8'h01 << $urandom_range(7));
        frame_bytes.push_back(ck_a);
        frame_bytes.push_back(ck_b);
        foreach (frame_bytes[i])
            if (i < max_bytes)
                push_byte(frame_bytes[i]);
    endtask

    // Mostly well-formed frames with random content; the rest is broken sync
    // pairs, line noise, cut-off frames and headers with absurd lengths.
    task automatic random_traffic(input int count);
        int stop_at;
        int pick;
        int len;
        int cut;
        stop_at = bytes_sent + count;
        while (bytes_sent < stop_at) begin
            pick = $urandom_range(99);
            if (pick < 72) begin
                len = ($urandom_range(9) == 0) ? $urandom_range(13, 60) : $urandom_range(0, 12);
                cut = ($urandom_range(19) == 0) ? $urandom_range(1, len + 7) : len + 8;
                send_frame(8'($urandom), 8'($urandom), len,
                           ($urandom_range(4) == 0) ? $urandom_range(1, 2) : 0, cut);
            end else if (pick < 84) begin
                push_byte($urandom_range(1) ? SYNC_FIRST : 8'($urandom));
                push_byte(($urandom_range(3) == 0) ? SYNC_SECOND : 8'($urandom));
            end else if (pick < 94 || frame_limit > 64) begin
                repeat ($urandom_range(1, 5)) push_byte(8'($urandom));
            end else begin
                // Header with a random 16-bit length; the limit ends it early.
                push_byte(SYNC_FIRST);
                push_byte(SYNC_SECOND);
                repeat (4) push_byte(8'($urandom));
                repeat ($urandom_range(0, 6)) push_byte(8'($urandom));
            end
        end
    endtask

    initial begin
        // Hold reset once, at the start of the run.
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Slow receiver, mostly eager sender; register at its reset value.
        send_idle_pct = 15;
        recv_idle_pct = 78;

        // Extreme class and id in a zero-length frame: length done goes
        // straight to the checksum, which must check out.
        send_frame(8'hFF, 8'h00, 0, 0, 8);
        // Pairs are compared as pairs: a good first byte with a bad second,
        // then the sync bytes swapped, both out of sync.
        push_byte(SYNC_FIRST);
        push_byte(8'h00);
        push_byte(SYNC_SECOND);
        push_byte(SYNC_FIRST);
        // Two payload bytes at the byte extremes, then a wrong checksum.
        push_byte(SYNC_FIRST);
        push_byte(SYNC_SECOND);
        push_byte(8'h00);
        push_byte(8'hFF);
        push_byte(8'h02);
        push_byte(8'h00);
        push_byte(8'h00);
        push_byte(8'hFF);
        push_byte(8'h00);
        push_byte(8'h00);

        random_traffic(420);
        drain_statuses();

        // Smallest legal limit: a one-byte payload frame is sent without CK_B and
        // overflows on the sync byte in its place, which must be dropped, not hunted.
        write_frame_limit(17'd8);
        send_frame(8'h5A, 8'hA5, 1, 0, 8);
        push_byte(SYNC_FIRST);
        random_traffic(60);
        drain_statuses();

        // Zero limit: every byte overflows.
        write_frame_limit(17'd0);
        push_byte(SYNC_FIRST);
        push_byte(SYNC_SECOND);
        drain_statuses();

        // Swap the idle odds: sender starves, receiver mostly ready.
        send_idle_pct = 78;
        recv_idle_pct = 15;
        write_frame_limit(17'($urandom_range(9, 40)));
        random_traffic(350);
        drain_statuses();

        write_frame_limit(17'h1FFFF);
        random_traffic(300);
        drain_statuses();

        // No idling at all: the largest meaningful limit, a long frame, then
        // more random traffic back to back.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_frame_limit(17'd65543);
        send_frame(8'($urandom), 8'($urandom), 40, 0, 48);
        random_traffic(160);
        drain_statuses();

        repeat (4) @(posedge aclk);
        if (mismatch_count == 0 && statuses_due == 0) begin
            $display("gnss_binary_frame_parser_core regression: pass");
        end else begin
            $display("gnss_binary_frame_parser_core regression: fail");
        end
        $finish;
    end

    // Watchdog: a hung handshake ends the run here.
    initial begin
        #RUN_LIMIT_NS;
        $display("gnss_binary_frame_parser_core regression: fail");
        $finish;
    end

endmodule
